// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/lis_pkg.sv =====
// package: word types, control/status structs and default sizes of the lis length tracker
package lis_pkg;

    // default sizes
    localparam int MAX_LENGTH_DEF = 1024;
    localparam int VALUE_BITS_DEF = 16;

    // fixed field widths of the words
    localparam int VALUE_W = 16;
    localparam int LEN_OUT_W = 11;

    // input word
    typedef struct packed {
        logic                 start_new;
        logic [VALUE_W-1:0]   value;
    } item_word_t;

    // result word
    typedef struct packed {
        logic [LEN_OUT_W-1:0] lis_length;
        logic                 overflow;
    } result_word_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture input word, set up search bounds
        logic read;    // read tail at the search midpoint
        logic step;    // narrow search bounds from the read tail
        logic update;  // append or lower a tail
        logic emit;    // load the result register
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic value_zero;   // captured value is zero
        logic search_more;  // search bounds not yet met
        logic out_free;     // result register can take a word
    } stat_t;

endpackage

// ===== hdl/lis_ctrl.sv =====
// controller: sequences load, binary search, table update and result emit
module lis_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  lis_pkg::stat_t  stat,
    output lis_pkg::cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CMP,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   idle_reg;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                priority if (stat.value_zero)
                begin
                    state_next = ST_EMIT;
                end
                else if (stat.search_more)
                begin
                    cmd.read   = 1'b1;
                    state_next = ST_CMP;
                end
                else
                begin
                    cmd.update = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_CMP:
            begin
                cmd.step   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // state and registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idle_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            idle_reg  <= (state_next == ST_IDLE);
        end
    end

    assign item_stall = !idle_reg;

endmodule

// ===== hdl/lis_dpath.sv =====
// datapath: tail memory, search bounds, length and overflow, result register
module lis_dpath
#(
    parameter int MAX_LENGTH = lis_pkg::MAX_LENGTH_DEF,
    parameter int VALUE_BITS = lis_pkg::VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lis_pkg::cmd_t         cmd,
    output lis_pkg::stat_t        stat,
    input  lis_pkg::item_word_t   item_word,
    output logic                  result_valid,
    input  logic                  result_stall,
    output lis_pkg::result_word_t result_word
);

    localparam int AW = $clog2(MAX_LENGTH);
    localparam int LW = $clog2(MAX_LENGTH + 1);

    logic [VALUE_BITS-1:0]        value_in;
    logic [VALUE_BITS-1:0]        v_reg;
    logic [VALUE_BITS-1:0]        rd_data_reg;
    logic [VALUE_BITS-1:0]        mem [MAX_LENGTH];
    logic [LW-1:0]                len_reg;
    logic [LW-1:0]                lo_reg;
    logic [LW-1:0]                hi_reg;
    logic [LW-1:0]                mid;
    logic                         ovf_reg;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [lis_pkg::LEN_OUT_W-1:0] len_out;
    logic                         out_valid_reg;
    lis_pkg::result_word_t        out_word_reg;

    // fit the value field to the working width
    if (VALUE_BITS > lis_pkg::VALUE_W)
    begin : g_val_ext
        assign value_in = {{(VALUE_BITS - lis_pkg::VALUE_W){1'b0}}, item_word.value};
    end
    else
    begin : g_val_cut
        assign value_in = item_word.value[VALUE_BITS-1:0];
    end

    // fit the length to the result field
    if (LW >= lis_pkg::LEN_OUT_W)
    begin : g_len_cut
        assign len_out = len_reg[lis_pkg::LEN_OUT_W-1:0];
    end
    else
    begin : g_len_ext
        assign len_out = {{(lis_pkg::LEN_OUT_W - LW){1'b0}}, len_reg};
    end

    // search midpoint
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // status to the controller
    assign stat.value_zero  = (v_reg == '0);
    assign stat.search_more = (lo_reg < hi_reg);
    assign stat.out_free    = !out_valid_reg || !result_stall;

    // table write: append at the end or lower the first tail not below the value
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = lo_reg[AW-1:0];
        if (cmd.update)
        begin
            if (lo_reg >= len_reg)
            begin
                if (len_reg < LW'(MAX_LENGTH))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = len_reg[AW-1:0];
                end
            end
            else
            begin
                mem_we = 1'b1;
            end
        end
    end

    // tail memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= v_reg;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[mid[AW-1:0]];
        end
    end

    // value and search bounds
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg  <= value_in;
            lo_reg <= '0;
            hi_reg <= item_word.start_new ? '0 : len_reg;
        end
        else if (cmd.step)
        begin
            if (rd_data_reg < v_reg)
            begin
                lo_reg <= mid + LW'(1);
            end
            else
            begin
                hi_reg <= mid;
            end
        end
    end

    // length and sticky overflow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (item_word.start_new)
            begin
                len_reg <= '0;
                ovf_reg <= 1'b0;
            end
        end
        else if (cmd.update && (lo_reg >= len_reg))
        begin
            if (len_reg < LW'(MAX_LENGTH))
            begin
                len_reg <= len_reg + LW'(1);
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_word_reg.lis_length <= len_out;
            out_word_reg.overflow   <= ovf_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule

// ===== hdl/lis_length_tracker_unit.sv =====
// top level: longest increasing subsequence length tracker
// per word: load, binary search of at most clog2(current length + 1) probes, table update,
//   then emit once the result register is free; a zero value skips search and update
// flow: the next word is taken only once the result is loaded; each probe is a
//   registered memory read and a compare; a finished word waiting on a stall holds off the next
// reset: length and overflow clear, tail memory not cleared; ready right after reset
module lis_length_tracker_unit
#(
    parameter int MAX_LENGTH = lis_pkg::MAX_LENGTH_DEF,
    parameter int VALUE_BITS = lis_pkg::VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  lis_pkg::item_word_t   item_word,
    output logic                  result_valid,
    input  logic                  result_stall,
    output lis_pkg::result_word_t result_word
);

    lis_pkg::cmd_t  cmd;
    lis_pkg::stat_t stat;

    // sequencer
    lis_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // tail table and result path
    lis_dpath
    #(
        .MAX_LENGTH (MAX_LENGTH),
        .VALUE_BITS (VALUE_BITS)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item_word    (item_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

endmodule

// ===== hdl/lis_checker.sv =====
// checker: port-level assertions for the lis length tracker, bound to the top level
`include "assert_macros.svh"

module lis_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_stall,
    input logic                  result_valid,
    input logic                  result_stall,
    input lis_pkg::result_word_t result_word
);

    // a stalled result stays offered
    `ASSERT_NEXT(a_res_hold, clk, rst_n, result_valid && result_stall, result_valid)

    // a stalled result word does not change
    `ASSERT_NEXT(a_res_stable, clk, rst_n, result_valid && result_stall, $stable(result_word))

    // an accepted word keeps the block busy for at least the next cycle
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, item_valid && !item_stall, item_stall)

    // a new result only appears after a busy cycle, never straight from idle
    `ASSERT_SAME(a_res_after_work, clk, rst_n, $rose(result_valid), $past(item_stall))

endmodule

bind lis_length_tracker_unit lis_checker u_lis_checker (.*);

// ===== tb/lis_tracker_checker.sv =====
`timescale 1ns / 100ps
// checker for the lis length tracker: watches both channels, predicts each result word and compares
module lis_tracker_checker
#(
    parameter int TABLE_DEPTH = lis_pkg::MAX_LENGTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_stall,
    input  lis_pkg::item_word_t   item_word,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  lis_pkg::result_word_t result_word,
    output int                    mismatches,
    output int                    pending,
    output int                    checked,
    output int                    overflow_reports,
    output int                    peak_length
);

    // shadow tail table and running length / overflow of the current sequence
    logic [lis_pkg::VALUE_W-1:0]   tails [TABLE_DEPTH];
    logic [lis_pkg::LEN_OUT_W-1:0] run_length = '0;
    logic                          run_overflow = 1'b0;

    // predicted length reports, oldest first
    lis_pkg::result_word_t length_reports_due [$];
    lis_pkg::result_word_t oldest_report;

    int fail_total = 0;
    int checked_total = 0;
    int overflow_total = 0;
    int longest_seen = 0;

    assign mismatches       = fail_total;
    assign pending          = length_reports_due.size();
    assign checked          = checked_total;
    assign overflow_reports = overflow_total;
    assign peak_length      = longest_seen;

    // patience placement of one value, returns the length report it causes
    function automatic lis_pkg::result_word_t place_value(input lis_pkg::item_word_t word);
        int lo;
        int hi;
        int mid;
        lis_pkg::result_word_t report;
        if (word.start_new)
        begin
            run_length   = '0;
            run_overflow = 1'b0;
        end
        // zero has no tail below it, the table stays as it is
        if (word.value != '0)
        begin
            lo = 0;
            hi = int'(run_length);
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (tails[mid] < word.value)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo >= int'(run_length))
            begin
                // extend, or drop and flag when the table is full
                if (int'(run_length) < TABLE_DEPTH)
                begin
                    tails[run_length] = word.value;
                    run_length = run_length + 1'b1;
                end
                else
                    run_overflow = 1'b1;
            end
            else
                tails[lo] = word.value;
        end
        report.lis_length = run_length;
        report.overflow   = run_overflow;
        return report;
    endfunction

    task automatic log_failure(input string what);
        if (fail_total < 10)
            $display("%0t: mismatch: %s", $time, what);
        fail_total++;
    endtask

    // results first: a result at this edge always belongs to an earlier word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                checked_total++;
                if (length_reports_due.size() == 0)
                    log_failure($sformatf("result length %0d overflow %0b with nothing due",
                                          result_word.lis_length, result_word.overflow));
                else
                begin
                    oldest_report = length_reports_due.pop_front();
                    if (result_word.lis_length !== oldest_report.lis_length)
                        log_failure($sformatf("lis_length expected %0d got %0d",
                                              oldest_report.lis_length,
                                              result_word.lis_length));
                    if (result_word.overflow !== oldest_report.overflow)
                        log_failure($sformatf("overflow expected %0b got %0b",
                                              oldest_report.overflow, result_word.overflow));
                end
            end
            if (item_valid && !item_stall)
            begin
                oldest_report = place_value(item_word);
                if (oldest_report.overflow)
                    overflow_total++;
                if (int'(oldest_report.lis_length) > longest_seen)
                    longest_seen = int'(oldest_report.lis_length);
                length_reports_due = {length_reports_due, oldest_report};
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// testbench top for the lis length tracker: clock, reset, word traffic and verdict
module tb_top;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int WORD_BUDGET     = 1600;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    lis_pkg::item_word_t   item_word = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    lis_pkg::result_word_t result_word;

    // traffic shaping flags
    logic send_idle = 1'b1;
    logic recv_idle = 1'b1;
    logic hold_off_req = 1'b0;
    int   hold_offs_done = 0;
    int   words_sent = 0;
    int   quiet_cycles = 0;

    int mismatches;
    int pending;
    int checked;
    int overflow_reports;
    int peak_length;

    always #2 clk = ~clk;

    lis_length_tracker_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_word    (item_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    lis_tracker_checker lis_check
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .item_word        (item_word),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .result_word      (result_word),
        .mismatches       (mismatches),
        .pending          (pending),
        .checked          (checked),
        .overflow_reports (overflow_reports),
        .peak_length      (peak_length)
    );

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // offer one word, optionally after a random gap, and wait for it to be taken
    task automatic send_word(input logic restart, input logic [lis_pkg::VALUE_W-1:0] val);
        int gap;
        gap = send_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_word  <= '{start_new: restart, value: val};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int pause;
        wait (rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                result_stall <= 1'b1;
                for (int c = 0; c < HOLD_OFF_CYCLES; c++)
                    @(posedge clk);
                hold_off_req = 1'b0;
                hold_offs_done++;
            end
            pause = recv_idle ? $urandom_range(0, 10) : 0;
            if (pause > 0)
            begin
                result_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int climb_top;
        int walk;
        int seq_len;
        int pick;
        logic [lis_pkg::VALUE_W-1:0] next_val;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: range edges, zero, repeats, lowering, restarts
        send_word(1'b1, 16'd1);
        send_word(1'b0, 16'hFFFF);
        send_word(1'b0, 16'h0000);     // zero leaves the table alone
        send_word(1'b0, 16'hFFFF);     // repeat of the top tail
        send_word(1'b0, 16'd1);        // repeat of the bottom tail
        send_word(1'b0, 16'd2);        // lowers the top tail
        send_word(1'b0, 16'h8000);
        send_word(1'b0, 16'h7FFF);     // lowers again
        send_word(1'b0, 16'hFFFE);
        send_word(1'b1, 16'h0000);     // restart with zero: empty table
        send_word(1'b0, 16'h0000);
        send_word(1'b0, 16'hFFFF);
        send_word(1'b0, 16'hAAAA);
        send_word(1'b0, 16'h5555);
        send_word(1'b1, 16'hFFFF);     // restart on a filled table
        send_word(1'b0, 16'd1);
        send_word(1'b0, 16'd3);
        send_word(1'b0, 16'd2);
        send_word(1'b0, 16'd4);
        send_word(1'b1, 16'd5);

        // back-to-back words while the result side holds off
        send_idle = 1'b0;
        hold_off_req = 1'b1;
        send_word(1'b1, 16'($urandom));
        repeat (23) send_word(1'b0, 16'($urandom));
        send_idle = 1'b1;

        // long climb that fills the table and runs past its capacity
        climb_top = 0;
        for (int step = 0; step < 1032; step++)
        begin
            if (step % 200 == 0)
            begin
                send_idle = ($urandom_range(0, 3) != 0);
                recv_idle = ($urandom_range(0, 3) != 0);
            end
            if (step > 0 && $urandom_range(0, 19) == 0)
                send_word(1'b0, 16'($urandom_range(1, climb_top)));
            climb_top += $urandom_range(1, 58);
            send_word(step == 0, 16'(climb_top));
        end

        // table full: extensions dropped, lowering and zero still handled
        for (int k = 0; k < 12; k++)
            send_word(1'b0, 16'($urandom_range(climb_top, 65535)));
        send_word(1'b0, 16'h0000);
        send_word(1'b0, 16'($urandom_range(1, climb_top)));
        send_word(1'b0, 16'hFFFF);

        // random sequences: mostly rising walks with dips, repeats and noise
        while (words_sent < WORD_BUDGET)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                send_idle = ($urandom_range(0, 3) != 0);
                recv_idle = ($urandom_range(0, 3) != 0);
            end
            seq_len = $urandom_range(1, 40);
            walk = $urandom_range(1, 2000);
            for (int k = 0; k < seq_len; k++)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    next_val = '0;
                else if (pick <= 2)
                    next_val = 16'($urandom_range(0, 65535));
                else if (pick == 3)
                    next_val = 16'(walk);
                else
                begin
                    walk = walk + $urandom_range(0, 1800) - 300;
                    if (walk < 1 || walk > 65535)
                        walk = $urandom_range(1, 1000);
                    next_val = 16'(walk);
                end
                send_word(k == 0 || $urandom_range(0, 63) == 0, next_val);
            end
        end
        item_valid <= 1'b0;

        // drain
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("summary: %0d words sent, %0d results checked, longest length %0d",
                 words_sent, checked, peak_length);
        $display("summary: %0d results with overflow set, %0d long result hold-offs",
                 overflow_reports, hold_offs_done);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
